FILE: hw/rtl/mrt_pkg.sv
// Shared types, constants and defaults of the mapped region table.
package mrt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int REPORT_MAX_DEF = 16;
  localparam int FILES_DEF      = 16;
  // Page size must be a power of two.
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [31:0] LOW_BOUND  = 32'h6000_0000;
  localparam logic [31:0] HIGH_BOUND = 32'h8000_0000;

  // Table entry as held in the RAM: {length, start}.
  localparam int ENTRY_W = 63;
  localparam int LIVE_W  = 5;
  // Wide enough to hold any slot or descriptor count in range.
  localparam int CNT_W   = 7;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_BAD   = 2'd3
  } act_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        mapped_start;
    logic               entry_valid;
    logic [31:0]        entry_start;
    logic [30:0]        entry_bytes;
    logic [LIVE_W-1:0]  live_count;
    logic               last;
  } result_t;

endpackage

FILE: hw/rtl/mrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mrt_out.sv
// Output register stage of the result stream.
module mrt_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  mrt_pkg::result_t                res,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mrt_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);

  mrt_pkg::result_t hold;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      hold <= res;
    end
  end

  assign m_tdata = {2'b00, hold.live_count, hold.entry_bytes, hold.entry_start,
                    hold.entry_valid, hold.mapped_start, hold.status};
  assign m_tlast = hold.last;

endmodule

FILE: hw/rtl/mrt_ctrl.sv
// Request checks, table walk over the entry RAM, commit and result generation.
module mrt_ctrl #(
  parameter int SLOTS      = mrt_pkg::SLOTS_DEF,
  parameter int REPORT_MAX = mrt_pkg::REPORT_MAX_DEF,
  parameter int FILES      = mrt_pkg::FILES_DEF,
  parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mrt_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [1:0]                        s_tuser,
  output logic [AW-1:0]                     ram_raddr,
  input  logic [mrt_pkg::ENTRY_W-1:0]       ram_rdata,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [mrt_pkg::ENTRY_W-1:0]       ram_wdata,
  input  logic                              out_free,
  output logic                              push,
  output mrt_pkg::result_t                  res
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t           state;
  mrt_pkg::act_t    act;
  logic [31:0]      addr;
  logic [30:0]      bytes;
  logic [32:0]      a_end;
  logic             pre_ok;
  logic [CW-1:0]    idx;
  logic             rd_valid;
  logic [AW-1:0]    rd_idx;
  logic             free_found;
  logic [AW-1:0]    free_idx;
  logic             hit;
  logic [AW-1:0]    hit_idx;
  logic [CW-1:0]    n;
  logic [SLOTS-1:0] used;
  logic [CW-1:0]    total;

  // Incoming item fields.
  logic [31:0] in_start;
  logic [31:0] in_bytes;
  logic [6:0]  in_desc;
  logic        req_ok;
  logic        desc_ok;

  assign in_start = s_tdata[31:0];
  assign in_bytes = s_tdata[63:32];
  assign in_desc  = s_tdata[73:67];

  assign desc_ok = !in_desc[6] && ({1'b0, in_desc[5:0]} < mrt_pkg::CNT_W'(FILES))
                   && s_tdata[74];
  assign req_ok  = (in_bytes != 32'd0) && !in_bytes[31]
                   && s_tdata[64] && s_tdata[65]
                   && (in_start >= mrt_pkg::LOW_BOUND) && (in_start < mrt_pkg::HIGH_BOUND)
                   && ((in_start & 32'(PAGE_BYTES - 1)) == 32'd0)
                   && (s_tdata[66] || desc_ok);

  assign s_tready = (state == ST_IDLE);

  // Entry under evaluation.
  logic        e_used;
  logic [31:0] e_start;
  logic [30:0] e_bytes;
  logic [32:0] e_end;
  logic [CW-1:0] lim;
  logic        q_emit;
  logic        stall;
  logic        eval;
  logic        scan_done;

  assign e_used  = used[rd_idx];
  assign e_start = ram_rdata[31:0];
  assign e_bytes = ram_rdata[62:32];
  assign e_end   = {1'b0, e_start} + {2'b00, e_bytes};

  assign lim = (mrt_pkg::CNT_W'(total) > mrt_pkg::CNT_W'(REPORT_MAX)) ?
               CW'(REPORT_MAX) : total;

  assign q_emit    = rd_valid && (act == mrt_pkg::ACT_QUERY) && e_used && (n < lim);
  assign stall     = q_emit && !out_free;
  assign eval      = (state == ST_SCAN) && rd_valid && !stall;
  assign scan_done = (state == ST_SCAN) && (idx == CW'(SLOTS)) && !rd_valid;

  // Hold the address during a stall so the read data stays put.
  assign ram_raddr = stall ? rd_idx : idx[AW-1:0];

  logic map_ok;
  logic fin;
  logic [CW-1:0] total_next;

  assign map_ok = pre_ok && free_found && !hit;
  assign fin    = (state == ST_FINISH) && out_free;

  always_comb begin
    total_next = total;
    if (fin && act == mrt_pkg::ACT_MAP && map_ok) begin
      total_next = total + 1'b1;
    end else if (fin && act == mrt_pkg::ACT_UNMAP && hit && total != '0) begin
      total_next = total - 1'b1;
    end
  end

  logic [CW+mrt_pkg::LIVE_W-1:0] live_ext;
  assign live_ext = {{mrt_pkg::LIVE_W{1'b0}}, total_next};

  always_comb begin
    res              = '0;
    res.live_count   = live_ext[mrt_pkg::LIVE_W-1:0];
    push             = 1'b0;
    if (state == ST_SCAN) begin
      push            = q_emit && out_free;
      res.entry_valid = 1'b1;
      res.entry_start = e_start;
      res.entry_bytes = e_bytes;
      res.last        = (CW'(n + 1'b1) == lim);
    end else if (state == ST_FINISH) begin
      push     = out_free;
      res.last = 1'b1;
      unique case (act)
        mrt_pkg::ACT_MAP: begin
          res.status       = !map_ok;
          res.mapped_start = map_ok ? addr : 32'd0;
        end
        mrt_pkg::ACT_UNMAP: res.status = !hit;
        mrt_pkg::ACT_QUERY: res.status = 1'b0;
        default:            res.status = 1'b1;
      endcase
    end
  end

  assign ram_we    = fin && (act == mrt_pkg::ACT_MAP) && map_ok;
  assign ram_waddr = free_idx;
  assign ram_wdata = {bytes, addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      total    <= '0;
      rd_valid <= 1'b0;
    end else begin
      total <= total_next;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (mrt_pkg::act_t'(s_tuser) == mrt_pkg::ACT_BAD) ? ST_FINISH : ST_SCAN;
          end
          rd_valid <= 1'b0;
        end
        ST_SCAN: begin
          if (!stall) begin
            rd_valid <= (idx != CW'(SLOTS));
          end
          if (scan_done) begin
            state <= (act == mrt_pkg::ACT_QUERY && total != '0) ? ST_IDLE : ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (act == mrt_pkg::ACT_MAP && map_ok) begin
              used[free_idx] <= 1'b1;
            end else if (act == mrt_pkg::ACT_UNMAP && hit) begin
              used[hit_idx] <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item capture and walk bookkeeping.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act        <= mrt_pkg::act_t'(s_tuser);
      addr       <= in_start;
      bytes      <= in_bytes[30:0];
      a_end      <= {1'b0, in_start} + {2'b00, in_bytes[30:0]};
      pre_ok     <= req_ok;
      idx        <= '0;
      free_found <= 1'b0;
      hit        <= 1'b0;
      n          <= '0;
    end else if (state == ST_SCAN) begin
      if (!stall && idx != CW'(SLOTS)) begin
        rd_idx <= idx[AW-1:0];
        idx    <= idx + 1'b1;
      end
      if (eval) begin
        unique case (act)
          mrt_pkg::ACT_MAP: begin
            if (!e_used && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (e_used && ({1'b0, addr} < e_end) && ({1'b0, e_start} < a_end)) begin
              hit <= 1'b1;
            end
          end
          mrt_pkg::ACT_UNMAP: begin
            if (e_used && e_start == addr && !hit) begin
              hit     <= 1'b1;
              hit_idx <= rd_idx;
            end
          end
          mrt_pkg::ACT_QUERY: begin
            if (q_emit) begin
              n <= n + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(total))
    else $error("live count disagrees with used marks");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> rd_valid && $stable(rd_idx))
    else $error("stalled entry lost");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output stage");

  a_map_free_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !used[free_idx])
    else $error("map commits into a live slot");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !scan_done) |=> !s_tready)
    else $error("item taken during a table walk");
`endif

endmodule

FILE: hw/rtl/mapped_region_table.sv
// Top level of the mapped region table: entry RAM, control and result stage.
//
// Keeps SLOTS mapped regions (start, length) in a RAM with live marks in
// flip-flops that reset clears, so the table is empty straight after reset.
// Every item but one with an unknown action walks the whole table through the
// single RAM read port, one slot a cycle while no query result is held off
// by the result stream. A map, an unmap or a query of an empty table has
// its result put into the output register after the walk; an unknown
// action has its result put there without a walk. A query of a non-empty
// table lists its live regions in slot order as the walk reaches them.
// A result held off by the result stream holds up its item until the output
// register is free. One item is handled at a time; the next is taken once
// the last result before it is in the output register, where it may wait.
// Map fails unless length is positive, both fixed and shared are set, the start
// is page aligned in 0x60000000..0x7FFFFFFF, a slot is free, no live region
// overlaps and (for file-backed maps) the descriptor is open and below FILES.
// PAGE_BYTES must be a power of two.
module mapped_region_table #(
  parameter int SLOTS      = mrt_pkg::SLOTS_DEF,
  parameter int REPORT_MAX = mrt_pkg::REPORT_MAX_DEF,
  parameter int FILES      = mrt_pkg::FILES_DEF,
  parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // region_start[31:0], region_bytes[63:32], want_fixed[64], want_shared[65],
  // want_anonymous[66], descriptor[73:67], descriptor_open[74], zero fill
  input  logic [mrt_pkg::IN_DATA_W-1:0]    s_tdata,
  // action[1:0]
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[0], mapped_start[32:1], entry_valid[33], entry_start[65:34],
  // entry_bytes[96:66], live_count[101:97], zero fill
  output logic [mrt_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tlast
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [AW-1:0]               ram_raddr;
  logic [mrt_pkg::ENTRY_W-1:0] ram_rdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [mrt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        out_free;
  logic                        push;
  mrt_pkg::result_t            res;

  mrt_ram #(
    .WIDTH (mrt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrt_ctrl #(
    .SLOTS      (SLOTS),
    .REPORT_MAX (REPORT_MAX),
    .FILES      (FILES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .out_free  (out_free),
    .push      (push),
    .res       (res)
  );

  mrt_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for the mapped region table: streamed map, unmap and query items.
module tb;
  import mrt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    act_t        action;
    logic [31:0] region_start;
    logic [31:0] region_bytes;
    logic        want_fixed;
    logic        want_shared;
    logic        want_anonymous;
    logic [6:0]  descriptor;
    logic        descriptor_open;
  } region_req_t;

  typedef struct {
    logic              status;
    logic [31:0]       mapped_start;
    logic              entry_valid;
    logic [31:0]       entry_start;
    logic [30:0]       entry_bytes;
    logic [LIVE_W-1:0] live_count;
    logic              last;
  } region_res_t;

  class region_scoreboard;
    logic        live_mark [SLOTS_DEF];
    logic [31:0] live_start [SLOTS_DEF];
    logic [30:0] live_len [SLOTS_DEF];
    int          live_total;
    region_res_t expected_results [$];
    int          fail_count;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        live_mark[i] = 1'b0;
        live_start[i] = '0;
        live_len[i] = '0;
      end
      live_total = 0;
      fail_count = 0;
    endfunction

    function void add_result(logic st, logic [31:0] ms, logic ev, logic [31:0] es,
                             logic [30:0] eb, logic lst);
      region_res_t e;
      e.status = st;
      e.mapped_start = ms;
      e.entry_valid = ev;
      e.entry_start = es;
      e.entry_bytes = eb;
      e.live_count = live_total[LIVE_W-1:0];
      e.last = lst;
      expected_results.push_back(e);
    endfunction

    // Commits nothing unless every check passes.
    function logic try_map(region_req_t r);
      int slot;
      logic [32:0] new_end;
      logic [32:0] old_end;
      slot = -1;
      if (r.region_bytes == 32'd0 || r.region_bytes[31]) return 1'b0;
      if (!r.want_fixed || !r.want_shared) return 1'b0;
      if (r.region_start < LOW_BOUND || r.region_start >= HIGH_BOUND) return 1'b0;
      if ((r.region_start % PAGE_BYTES_DEF) != 0) return 1'b0;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (!live_mark[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) return 1'b0;
      new_end = {1'b0, r.region_start} + {1'b0, r.region_bytes};
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (live_mark[i]) begin
          old_end = {1'b0, live_start[i]} + {2'b0, live_len[i]};
          if ({1'b0, r.region_start} < old_end && {1'b0, live_start[i]} < new_end)
            return 1'b0;
        end
      end
      if (!r.want_anonymous) begin
        if (r.descriptor[6] || r.descriptor >= FILES_DEF || !r.descriptor_open) return 1'b0;
      end
      live_mark[slot] = 1'b1;
      live_start[slot] = r.region_start;
      live_len[slot] = r.region_bytes[30:0];
      live_total++;
      return 1'b1;
    endfunction

    function logic try_unmap(logic [31:0] addr);
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (live_mark[i] && live_start[i] == addr) begin
          live_mark[i] = 1'b0;
          live_start[i] = '0;
          live_len[i] = '0;
          if (live_total > 0) live_total--;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(region_req_t r);
      logic ok;
      int n;
      n = 0;
      case (r.action)
        ACT_MAP: begin
          ok = try_map(r);
          add_result(!ok, ok ? r.region_start : 32'd0, 1'b0, '0, '0, 1'b1);
        end
        ACT_UNMAP: begin
          ok = try_unmap(r.region_start);
          add_result(!ok, '0, 1'b0, '0, '0, 1'b1);
        end
        ACT_QUERY: begin
          for (int i = 0; i < SLOTS_DEF && n < REPORT_MAX_DEF; i++) begin
            if (live_mark[i]) begin
              add_result(1'b0, '0, 1'b1, live_start[i], live_len[i], 1'b0);
              n++;
            end
          end
          if (n == 0) add_result(1'b0, '0, 1'b0, '0, '0, 1'b1);
          else expected_results[$].last = 1'b1;
        end
        default: add_result(1'b1, '0, 1'b0, '0, '0, 1'b1);
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic lst);
      region_res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h last %b", $time, d, lst);
        fail_count++;
        return;
      end
      e = expected_results.pop_front();
      check_field("status", 32'(e.status), 32'(d[0]));
      check_field("mapped_start", e.mapped_start, d[32:1]);
      check_field("entry_valid", 32'(e.entry_valid), 32'(d[33]));
      check_field("entry_start", e.entry_start, d[65:34]);
      check_field("entry_bytes", 32'(e.entry_bytes), 32'(d[96:66]));
      check_field("live_count", 32'(e.live_count), 32'(d[101:97]));
      check_field("last", 32'(e.last), 32'(lst));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  region_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_cnt = 0;
  bit filling = 1'b1;

  mapped_region_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: switches between always ready, coin-toss and a fixed duty pattern.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(40, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (stall_cnt % 11) < 3;
    endcase
    stall_cnt <= stall_cnt + 1;
  end

  function automatic logic [IN_DATA_W-1:0] pack_req(region_req_t r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[31:0] = r.region_start;
    d[63:32] = r.region_bytes;
    d[64] = r.want_fixed;
    d[65] = r.want_shared;
    d[66] = r.want_anonymous;
    d[73:67] = r.descriptor;
    d[74] = r.descriptor_open;
    return d;
  endfunction

  function automatic region_req_t map_req(logic [31:0] addr, logic [31:0] len, logic anon,
                                          logic [6:0] desc, logic dopen);
    region_req_t r;
    r.action = ACT_MAP;
    r.region_start = addr;
    r.region_bytes = len;
    r.want_fixed = 1'b1;
    r.want_shared = 1'b1;
    r.want_anonymous = anon;
    r.descriptor = desc;
    r.descriptor_open = dopen;
    return r;
  endfunction

  function automatic region_req_t plain_req(act_t a, logic [31:0] addr);
    region_req_t r;
    r = map_req(addr, $urandom, 1'($urandom), 7'($urandom), 1'($urandom));
    r.action = a;
    return r;
  endfunction

  function automatic logic [31:0] pick_live_start();
    logic [31:0] starts [$];
    for (int i = 0; i < SLOTS_DEF; i++)
      if (sb.live_mark[i]) starts.push_back(sb.live_start[i]);
    if (starts.size() == 0) return {3'b011, 17'($urandom_range(0, 255)), 12'h000};
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  function automatic region_req_t good_map();
    logic [31:0] addr;
    logic [31:0] len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) addr = {3'b011, 17'($urandom), 12'h000};
    else addr = {3'b011, 17'($urandom_range(0, 255)), 12'h000};
    pick = $urandom_range(0, 9);
    if (pick < 7) len = 32'($urandom_range(1, 4)) << 12;
    else if (pick < 9) len = $urandom_range(1, 32'h4000);
    else len = $urandom_range(1, 32'h7FFF_FFFF);
    return map_req(addr, len, 1'($urandom), 7'($urandom_range(0, FILES_DEF - 1)), 1'b1);
  endfunction

  // A map that is well formed but for one broken check.
  function automatic region_req_t broken_map();
    region_req_t r;
    r = good_map();
    case ($urandom_range(0, 7))
      0: r.region_bytes = $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)};
      1: r.want_fixed = 1'b0;
      2: r.want_shared = 1'b0;
      3: r.region_start = $urandom_range(0, 1) ? {3'b010, 29'($urandom)} : {1'b1, 31'($urandom)};
      4: r.region_start[11:0] = 12'($urandom_range(1, 4095));
      5: begin
        r.want_anonymous = 1'b0;
        r.descriptor = $urandom_range(0, 1) ? {1'b1, 6'($urandom)} : 7'($urandom_range(16, 63));
      end
      6: begin
        r.want_anonymous = 1'b0;
        r.descriptor_open = 1'b0;
      end
      default: r.region_start = pick_live_start() + (32'($urandom_range(0, 3)) << 12);
    endcase
    return r;
  endfunction

  function automatic region_req_t random_req();
    region_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (filling) begin
      if (pick < 60) r = good_map();
      else if (pick < 68) r = plain_req(ACT_UNMAP, pick_live_start());
      else if (pick < 78) r = plain_req(ACT_QUERY, $urandom);
      else if (pick < 90) r = broken_map();
      else pick = 200;
    end else begin
      if (pick < 50) r = plain_req(ACT_UNMAP, pick_live_start());
      else if (pick < 58) r = plain_req(ACT_UNMAP, $urandom);
      else if (pick < 68) r = good_map();
      else if (pick < 85) r = plain_req(ACT_QUERY, $urandom);
      else pick = 200;
    end
    // noise: every field at random
    if (pick == 200) begin
      r = plain_req(act_t'($urandom_range(0, 3)), $urandom);
      r.want_fixed = 1'($urandom);
      r.want_shared = 1'($urandom);
    end
    return r;
  endfunction

  task automatic push(region_req_t r);
    s_tvalid <= 1'b1;
    s_tuser <= r.action;
    s_tdata <= pack_req(r);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 11);
    end
  endtask

  initial begin
    region_req_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push(plain_req(ACT_QUERY, 32'h0));
    push(plain_req(ACT_UNMAP, 32'h6000_0000));
    push(map_req(32'h6000_0000, 32'h1000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6000_0000, 32'h1000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6010_0000, 32'h0, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6010_0000, 32'h8000_0000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6010_0000, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b0));
    r = map_req(32'h6010_0000, 32'h1000, 1'b1, 7'd0, 1'b0);
    r.want_fixed = 1'b0;
    push(r);
    r.want_fixed = 1'b1;
    r.want_shared = 1'b0;
    push(r);
    push(map_req(32'h5FFF_F000, 32'h1000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h8000_0000, 32'h1000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6000_0800, 32'h1000, 1'b1, 7'd0, 1'b0));
    // longest length at the top page: the end runs past the high bound
    push(map_req(32'h7FFF_F000, 32'h7FFF_FFFF, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'h7F, 1'b1));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'h40, 1'b1));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'd16, 1'b1));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'd63, 1'b1));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'd15, 1'b0));
    push(map_req(32'h6000_1000, 32'h1000, 1'b0, 7'd15, 1'b1));
    push(map_req(32'h7000_0000, 32'h1_0000, 1'b0, 7'd0, 1'b1));
    push(map_req(32'h6FFF_F000, 32'h2000, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h7000_F000, 32'h1, 1'b1, 7'd0, 1'b0));
    push(map_req(32'h7001_0000, 32'h1, 1'b1, 7'd0, 1'b0));
    push(plain_req(ACT_BAD, 32'h6000_0000));
    push(plain_req(ACT_QUERY, 32'h0));
    push(plain_req(ACT_UNMAP, 32'h6000_1000));
    push(plain_req(ACT_UNMAP, 32'h6000_1000));
    push(plain_req(ACT_UNMAP, 32'h7FFF_F000));

    // Alternate fill and drain phases so the table reaches both full and empty.
    for (int k = 0; k < 250; k++) begin
      if (sb.live_total == SLOTS_DEF) filling = 1'b0;
      else if (sb.live_total == 0) filling = 1'b1;
      else if ($urandom_range(0, 19) == 0) filling = ~filling;
      push(random_req());
    end
    s_tvalid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
